@@ sv/bbrc_pkg.sv @@
package bbrc_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 4096;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int PTR_W      = IDX_W + 1;

  // Field widths
  localparam int OP_W    = 2;
  localparam int DATA_W  = 8;
  localparam int TALLY_W = 17;
  localparam int OCC_W   = 13;

  localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(65536);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_STATUS = 2'd2
  } op_t;

  // Request from the control logic to one ring
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [DATA_W-1:0] wdata;
  } ring_req_t;

  // Status returned by one ring
  typedef struct packed {
    logic [PTR_W-1:0]  used;
    logic              full;
    logic              empty;
    logic [DATA_W-1:0] rdata;
  } ring_sts_t;

endpackage

@@ sv/bbrc_ram.sv @@
module bbrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read data holds when not enabled
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/bbrc_ring.sv @@
module bbrc_ring (
  input  logic                clk,
  input  logic                rst_n,
  input  bbrc_pkg::ring_req_t req,
  output bbrc_pkg::ring_sts_t sts
);

  import bbrc_pkg::*;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [PTR_W-1:0] used;

  // Free-running pointers, one extra bit tells full from empty
  assign used     = head_r - tail_r;
  assign head_nxt = req.push ? head_r + PTR_W'(1) : head_r;
  assign tail_nxt = req.pop  ? tail_r + PTR_W'(1) : tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  bbrc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (req.push),
    .waddr (head_r[IDX_W-1:0]),
    .wdata (req.wdata),
    .re    (req.pop),
    .raddr (tail_r[IDX_W-1:0]),
    .rdata (sts.rdata)
  );

  assign sts.used  = used;
  assign sts.full  = used[PTR_W-1];
  assign sts.empty = (used == '0);

endmodule

@@ sv/bidirectional_byte_ring_channel_unit.sv @@
// Channel    Direction  Transfer when        Payload
// in_        input      in_valid & in_ready  operation, end_req, write_data, last_in_transfer
// out_       output     out_valid&out_ready  read_data, accepted, transfer_count, occupancy
//
// One item per cycle unless stalled; results pass the lookup stage and output register.
// Pointers and the transfer tally are registers; each ring is a one-port-write,
// one-port-read RAM whose registered read delivers the byte in the cycle after the pop.
// Reset clears pointers, tally and valids; ring contents stay undefined.
// A stalled output holds the lookup stage, and in_ready drops until it moves.
module bidirectional_byte_ring_channel_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bbrc_pkg::OP_W-1:0]        in_operation,
  input  logic                             in_end_req,
  input  logic [bbrc_pkg::DATA_W-1:0]      in_write_data,
  input  logic                             in_last_in_transfer,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bbrc_pkg::DATA_W-1:0]      out_read_data,
  output logic                             out_accepted,
  output logic [bbrc_pkg::TALLY_W-1:0]     out_transfer_count,
  output logic [bbrc_pkg::OCC_W-1:0]       out_occupancy
);

  import bbrc_pkg::*;

  ring_req_t tm_req, ts_req;
  ring_sts_t tm_sts, ts_sts;
  ring_sts_t rx_sts, tx_sts;

  logic               in_xfer;
  logic               is_wr, is_rd, ok;
  logic [TALLY_W-1:0] tally_r, tally_nxt, count;
  logic [PTR_W-1:0]   occ;

  logic               s1_v_r, s1_v_nxt;
  logic               s1_rd_r;
  logic               s1_slave_r;
  logic               s1_acc_r;
  logic [TALLY_W-1:0] s1_cnt_r;
  logic [OCC_W-1:0]   s1_occ_r;
  logic               s1_adv;

  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_read_data_r;
  logic               out_accepted_r;
  logic [TALLY_W-1:0] out_transfer_count_r;
  logic [OCC_W-1:0]   out_occupancy_r;

  // Pipeline flow control
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_v_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  // Decode and pick rings: writes go to the far end, reads from the near end
  always_comb begin
    is_wr = 1'b0;
    is_rd = 1'b0;
    case (op_t'(in_operation))
      OP_WRITE: is_wr = 1'b1;
      OP_READ:  is_rd = 1'b1;
      default:  ;
    endcase
  end

  assign rx_sts = in_end_req ? ts_sts : tm_sts;
  assign tx_sts = in_end_req ? tm_sts : ts_sts;
  assign ok     = (is_wr && !tx_sts.full) || (is_rd && !rx_sts.empty);

  always_comb begin
    tm_req.push  = in_xfer && is_wr && ok && in_end_req;
    tm_req.pop   = in_xfer && is_rd && ok && !in_end_req;
    tm_req.wdata = in_write_data;
    ts_req.push  = in_xfer && is_wr && ok && !in_end_req;
    ts_req.pop   = in_xfer && is_rd && ok && in_end_req;
    ts_req.wdata = in_write_data;
  end

  bbrc_ring u_tm (.clk(clk), .rst_n(rst_n), .req(tm_req), .sts(tm_sts));
  bbrc_ring u_ts (.clk(clk), .rst_n(rst_n), .req(ts_req), .sts(ts_sts));

  // Tally: count accepted bytes, saturate, clear on last byte
  always_comb begin
    count     = tally_r;
    tally_nxt = tally_r;
    if (is_wr || is_rd) begin
      if (ok && tally_r < TALLY_MAX) begin
        count = tally_r + TALLY_W'(1);
      end
      tally_nxt = in_last_in_transfer ? '0 : count;
    end
  end

  // Occupancy of the near ring after the operation
  assign occ = rx_sts.used - PTR_W'(is_rd && ok);

  assign s1_v_nxt      = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  assign out_valid_nxt = s1_v_r && s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r     <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        tally_r <= tally_nxt;
      end
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Lookup stage: hold the result while the RAM read completes
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_rd_r    <= is_rd && ok;
      s1_slave_r <= in_end_req;
      s1_acc_r   <= ok;
      s1_cnt_r   <= count;
      s1_occ_r   <= OCC_W'(occ);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (s1_v_r && s1_adv) begin
      out_read_data_r      <= s1_rd_r ? (s1_slave_r ? ts_sts.rdata : tm_sts.rdata) : '0;
      out_accepted_r       <= s1_acc_r;
      out_transfer_count_r <= s1_cnt_r;
      out_occupancy_r      <= s1_occ_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_read_data_r;
  assign out_accepted       = out_accepted_r;
  assign out_transfer_count = out_transfer_count_r;
  assign out_occupancy      = out_occupancy_r;

endmodule

@@ sv/bbrc_chk.sv @@
module bbrc_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bbrc_pkg::DATA_W-1:0]  out_read_data,
  input logic                         out_accepted,
  input logic [bbrc_pkg::TALLY_W-1:0] out_transfer_count,
  input logic [bbrc_pkg::OCC_W-1:0]   out_occupancy
);

  import bbrc_pkg::*;

  // Stalled result holds its read data, accepted flag and transfer count
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
      && $stable(out_accepted) && $stable(out_transfer_count))
    else $error("result changed while stalled");

  // A rejected or status operation returns no data
  a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_read_data == '0)
    else $error("data on unaccepted result");

  // An accepted byte always counts in the transfer
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_transfer_count != '0)
    else $error("accepted byte not counted");

  // Ranges of tally and occupancy
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_transfer_count <= TALLY_MAX
      && out_occupancy <= OCC_W'(RING_DEPTH))
    else $error("count or occupancy out of range");

  // No result is valid right after a reset
  a_first: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

endmodule

bind bidirectional_byte_ring_channel_unit bbrc_chk u_bbrc_chk (.*);

@@ bench/tb_bidirectional_byte_ring_channel_unit.sv @@
module tb_bidirectional_byte_ring_channel_unit;
  import bbrc_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam logic END_MASTER = 1'b0;
  localparam logic END_SLAVE  = 1'b1;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_LIMIT    = 100000;

  typedef struct {
    logic [DATA_W-1:0]  read_data;
    logic               accepted;
    logic [TALLY_W-1:0] transfer_count;
    logic [OCC_W-1:0]   occupancy;
  } channel_result_t;

  // Mirror of both byte rings and the transfer tally; holds results still owed
  class ring_channel_tracker;
    logic [DATA_W-1:0]  ring_bytes [2][RING_DEPTH];
    logic [PTR_W-1:0]   ring_head [2];
    logic [PTR_W-1:0]   ring_tail [2];
    logic [TALLY_W-1:0] tally;
    channel_result_t    owed_results [$];
    int unsigned        errors;

    function new();
      for (int r = 0; r < 2; r++) begin
        ring_head[r] = '0;
        ring_tail[r] = '0;
      end
      tally  = '0;
      errors = 0;
    endfunction

    function logic [PTR_W-1:0] fill(int ring);
      return ring_head[ring] - ring_tail[ring];
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Ring index equals the end that reads it: 0 toward master, 1 toward slave
    function void note_transfer(logic [OP_W-1:0] op, logic end_sel,
                                logic [DATA_W-1:0] data, logic last);
      channel_result_t r;
      int rx;
      int tx;
      rx = int'(end_sel);
      tx = int'(!end_sel);
      r.read_data = '0;
      r.accepted  = 1'b0;
      case (op)
        OP_WRITE: begin
          if (fill(tx) < RING_DEPTH) begin
            ring_bytes[tx][ring_head[tx][IDX_W-1:0]] = data;
            ring_head[tx]++;
            r.accepted = 1'b1;
          end
        end
        OP_READ: begin
          if (fill(rx) != 0) begin
            r.read_data = ring_bytes[rx][ring_tail[rx][IDX_W-1:0]];
            ring_tail[rx]++;
            r.accepted = 1'b1;
          end
        end
        default: ;
      endcase
      if (op == OP_WRITE || op == OP_READ) begin
        if (r.accepted && tally < TALLY_MAX) tally++;
        r.transfer_count = tally;
        // last closes the transfer whether or not the byte went through
        if (last) tally = '0;
      end else begin
        r.transfer_count = tally;
      end
      r.occupancy = OCC_W'(fill(rx));
      owed_results.push_back(r);
    endfunction

    function void check_result(channel_result_t got);
      channel_result_t want;
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: read_data %0d accepted %0d count %0d occ %0d",
               got.read_data, got.accepted, got.transfer_count, got.occupancy);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data mismatch: expected %0d, actual %0d", want.read_data, got.read_data);
        errors++;
      end
      if (got.accepted !== want.accepted) begin
        $error("accepted mismatch: expected %0d, actual %0d", want.accepted, got.accepted);
        errors++;
      end
      if (got.transfer_count !== want.transfer_count) begin
        $error("transfer_count mismatch: expected %0d, actual %0d",
               want.transfer_count, got.transfer_count);
        errors++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy mismatch: expected %0d, actual %0d", want.occupancy, got.occupancy);
        errors++;
      end
    endfunction
  endclass

  logic               clk                 = 1'b0;
  logic               rst_n               = 1'b0;
  logic               in_valid            = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    in_operation        = OP_STATUS;
  logic               in_end_req          = END_MASTER;
  logic [DATA_W-1:0]  in_write_data       = '0;
  logic               in_last_in_transfer = 1'b0;
  logic               out_valid;
  logic               out_ready           = 1'b0;
  logic [DATA_W-1:0]  out_read_data;
  logic               out_accepted;
  logic [TALLY_W-1:0] out_transfer_count;
  logic [OCC_W-1:0]   out_occupancy;

  ring_channel_tracker tracker = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit holdoff_start = 1'b0;
  int holdoff_left = 0;

  bidirectional_byte_ring_channel_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_end_req          (in_end_req),
    .in_write_data       (in_write_data),
    .in_last_in_transfer (in_last_in_transfer),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_read_data       (out_read_data),
    .out_accepted        (out_accepted),
    .out_transfer_count  (out_transfer_count),
    .out_occupancy       (out_occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check each result transfer, then pick next ready (long hold-off wins)
  always @(posedge clk) begin
    channel_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.read_data      = out_read_data;
      got.accepted       = out_accepted;
      got.transfer_count = out_transfer_count;
      got.occupancy      = out_occupancy;
      tracker.check_result(got);
    end
    if (holdoff_start) begin
      holdoff_left  = HOLDOFF_CYCLES;
      holdoff_start = 1'b0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one operation, idling first at random; note it once transferred
  task automatic send_op(input logic [OP_W-1:0] op, input logic end_sel,
                         input logic [DATA_W-1:0] data, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_operation        <= op;
    in_end_req          <= end_sel;
    in_write_data       <= data;
    in_last_in_transfer <= last;
    do @(posedge clk); while (!in_ready);
    tracker.note_transfer(op, end_sel, data, last);
  endtask

  // Run of one operation from one end, last flag on the final byte
  task automatic send_burst(input logic [OP_W-1:0] op, input logic end_sel, input int len);
    for (int i = 0; i < len; i++)
      send_op(op, end_sel, DATA_W'($urandom_range(255)), i == len - 1);
  endtask

  // Mostly write-then-drain transfers between the ends, some single noise ops
  task automatic random_traffic(input int n);
    int sent;
    int len;
    int pick;
    logic end_sel;
    sent = 0;
    while (sent < n) begin
      pick    = $urandom_range(99);
      end_sel = 1'($urandom_range(1));
      if (pick < 70) begin
        len = $urandom_range(1, 12);
        send_burst(OP_WRITE, end_sel, len);
        if ($urandom_range(3) == 0)
          send_op(OP_STATUS, !end_sel, DATA_W'($urandom_range(255)),
                  1'($urandom_range(1)));
        pick = $urandom_range(1, len + 2);
        send_burst(OP_READ, !end_sel, pick);
        sent += len + pick;
      end else begin
        send_op(OP_W'($urandom_range(3)), end_sel, DATA_W'($urandom_range(255)),
                1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int drain_wait;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty rings: status, reads with nothing waiting
    send_op(OP_STATUS, END_MASTER, 8'h00, 1'b0);
    send_op(OP_STATUS, END_SLAVE, 8'hFF, 1'b1);
    send_op(OP_READ, END_MASTER, 8'h00, 1'b0);
    send_op(OP_READ, END_SLAVE, 8'hFF, 1'b1);
    // Writes both ways, extreme bytes
    send_op(OP_WRITE, END_MASTER, 8'h00, 1'b0);
    send_op(OP_WRITE, END_MASTER, 8'hFF, 1'b0);
    send_op(OP_WRITE, END_MASTER, 8'hA5, 1'b1);
    send_op(OP_WRITE, END_SLAVE, 8'h5A, 1'b0);
    send_op(OP_WRITE, END_SLAVE, 8'hFF, 1'b1);
    // Status ignores last; reserved code acts as status
    send_op(OP_STATUS, END_SLAVE, 8'h00, 1'b1);
    send_op(OP_RESERVED, END_MASTER, 8'hFF, 1'b1);
    send_op(OP_RESERVED, END_SLAVE, 8'h00, 1'b0);
    // Drain, overrunning each ring by one
    send_op(OP_READ, END_SLAVE, 8'h00, 1'b0);
    send_op(OP_READ, END_SLAVE, 8'h00, 1'b0);
    send_op(OP_READ, END_SLAVE, 8'h00, 1'b0);
    send_op(OP_READ, END_SLAVE, 8'h00, 1'b1);
    send_op(OP_READ, END_MASTER, 8'h00, 1'b0);
    send_op(OP_READ, END_MASTER, 8'h00, 1'b0);
    send_op(OP_READ, END_MASTER, 8'h00, 1'b1);
    // Accepted write, then rejected read with last still clears the tally
    send_op(OP_WRITE, END_SLAVE, 8'h81, 1'b0);
    send_op(OP_READ, END_SLAVE, 8'h00, 1'b1);
    send_op(OP_STATUS, END_MASTER, 8'h00, 1'b0);
    send_op(OP_READ, END_MASTER, 8'h00, 1'b1);

    // No idling, then a long receiver hold-off while items keep coming
    random_traffic(400);
    holdoff_start = 1'b1;
    random_traffic(60);
    // Pause the sender until every result is back
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);

    send_idle_pct  = 84;
    recv_stall_pct = 0;
    random_traffic(460);
    send_idle_pct  = 0;
    recv_stall_pct = 84;
    random_traffic(460);
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    random_traffic(460);

    in_valid <= 1'b0;
    drain_wait = 0;
    while (tracker.pending() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (8) @(posedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d results never arrived", tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
